[rtl/swl1_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swl1_pkg
// Shared types and constants of the subband weighted L1 norm core.
// ----------------------------------------------------------------------------
package swl1_pkg;

    // field widths
    localparam int COEF_W   = 24;
    localparam int WIDX_W   = 6;
    localparam int WGT_W    = 16;
    localparam int NORM_W   = 63;
    localparam int LEN_W    = 12;
    localparam int REG_DIMS = 6;
    localparam int WGT_DEPTH = 64;

    // magnitude path
    localparam int SQ_W       = 48;
    localparam int REM_W      = 26;
    localparam int ROOT_STEPS = 24;
    localparam int STEP_W     = 5;
    localparam int PROD_W     = COEF_W + WGT_W;

    // configuration port
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;
    localparam logic [2:0] REG_LEN0 = 3'd0;
    localparam logic [2:0] REG_LEN5 = 3'd5;
    localparam logic [2:0] REG_CPLX = 3'd6;

    // action codes
    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_COEF    = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_ADD,
        S_ROOT,
        S_MUL,
        S_ACC
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic sq;
        logic add;
        logic root;
        logic mul;
        logic acc;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic coef;
        logic cplx;
        logic root_done;
        logic out_block;
    } t_sts;

endpackage

[rtl/swl1_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swl1 channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface swl1_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [5:0]  weight_index;
    logic [15:0] weight_value;
    logic signed [23:0] coef_real;
    logic signed [23:0] coef_imag;

    modport source (output valid, action, weight_index, weight_value, coef_real,
                    coef_imag, input ready);
    modport sink (input valid, action, weight_index, weight_value, coef_real,
                  coef_imag, output ready);
endinterface

interface swl1_out_if;
    logic        valid;
    logic        ready;
    logic [62:0] norm_value;
    logic        saturated;

    modport source (output valid, norm_value, saturated, input ready);
    modport sink (input valid, norm_value, saturated, output ready);
endinterface

[rtl/swl1_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swl1_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module swl1_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/swl1_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swl1_ctrl
// Sequencer: steps one coefficient through magnitude (complex mode only), multiply and accumulate.
// ----------------------------------------------------------------------------
module swl1_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  swl1_pkg::t_sts    i_sts,
    output swl1_pkg::t_cmd    o_cmd
);

    swl1_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swl1_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            swl1_pkg::S_IDLE: begin
                if (i_valid && i_sts.coef) begin
                    n_state = i_sts.cplx ? swl1_pkg::S_SQ : swl1_pkg::S_MUL;
                end
            end
            swl1_pkg::S_SQ:   n_state = swl1_pkg::S_ADD;
            swl1_pkg::S_ADD:  n_state = swl1_pkg::S_ROOT;
            swl1_pkg::S_ROOT: begin
                if (i_sts.root_done) begin
                    n_state = swl1_pkg::S_MUL;
                end
            end
            swl1_pkg::S_MUL:  n_state = swl1_pkg::S_ACC;
            swl1_pkg::S_ACC: begin
                if (!i_sts.out_block) begin
                    n_state = swl1_pkg::S_IDLE;
                end
            end
            default: n_state = swl1_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            swl1_pkg::S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.take = i_valid;
            end
            swl1_pkg::S_SQ:   o_cmd.sq   = 1'b1;
            swl1_pkg::S_ADD:  o_cmd.add  = 1'b1;
            swl1_pkg::S_ROOT: o_cmd.root = 1'b1;
            swl1_pkg::S_MUL:  o_cmd.mul  = 1'b1;
            swl1_pkg::S_ACC:  o_cmd.acc  = !i_sts.out_block;
            default: o_cmd = '0;
        endcase
    end

`ifndef SYNTHESIS
    // a coefficient always starts a multi-cycle pass
    a_coef_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.take && i_sts.coef) |=> (r_state != swl1_pkg::S_IDLE))
        else $error("coefficient transfer did not leave idle");
    // accumulate completes unless the result register is blocked
    a_acc_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == swl1_pkg::S_ACC && !i_sts.out_block) |=> (r_state == swl1_pkg::S_IDLE))
        else $error("accumulate did not return to idle");
`endif

endmodule

[rtl/swl1_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swl1_dp
// Datapath: coordinate counters, weight table, magnitude, saturating sum.
// ----------------------------------------------------------------------------
module swl1_dp #(
    parameter int NUM_DIMS    = 6,
    parameter int MAX_DIM_LEN = 2048
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  swl1_pkg::t_cmd                i_cmd,
    output swl1_pkg::t_sts                o_sts,
    input  logic [1:0]                    i_action,
    input  logic [swl1_pkg::WIDX_W-1:0]   i_weight_index,
    input  logic [swl1_pkg::WGT_W-1:0]    i_weight_value,
    input  logic signed [swl1_pkg::COEF_W-1:0] i_coef_real,
    input  logic signed [swl1_pkg::COEF_W-1:0] i_coef_imag,
    input  logic [swl1_pkg::LEN_W-1:0]    i_len [swl1_pkg::REG_DIMS],
    input  logic                          i_cplx,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [swl1_pkg::NORM_W-1:0]   o_norm,
    output logic                          o_sat
);

    localparam int CW = $clog2(MAX_DIM_LEN);
    localparam int NW = CW + 1;
    localparam int EW = (NW > swl1_pkg::LEN_W) ? NW : swl1_pkg::LEN_W;
    localparam int RD = swl1_pkg::REG_DIMS;

    // coordinate counters and band decode
    logic [CW-1:0] r_coord [RD];
    logic [CW-1:0] n_coord [RD];
    logic [NW-1:0] w_n     [RD];
    logic [RD-1:0] w_band;
    logic [RD-1:0] w_lastel;
    logic [RD:0]   w_carry;

    for (genvar d = 0; d < RD; d++) begin : g_dim
        logic [EW-1:0] w_lx;
        logic [EW-1:0] w_mx;
        assign w_lx = EW'(i_len[d]);
        assign w_mx = EW'(MAX_DIM_LEN);
        always_comb begin
            if (d >= NUM_DIMS || i_len[d] < swl1_pkg::LEN_W'(2)) begin
                w_n[d] = NW'(1);
            end else if (w_lx > w_mx) begin
                w_n[d] = NW'(w_mx);
            end else begin
                w_n[d] = NW'(w_lx);
            end
        end
        assign w_band[d]   = (w_n[d] > NW'(1)) && ({1'b0, r_coord[d]} >= (w_n[d] >> 1));
        assign w_lastel[d] = w_band[d] && ({1'b0, r_coord[d]} == w_n[d] - NW'(1));
    end

    // column-major advance, dimension 0 fastest
    always_comb begin
        w_carry[0] = 1'b1;
        for (int d = 0; d < RD; d++) begin
            n_coord[d]   = r_coord[d];
            w_carry[d+1] = 1'b0;
            if (w_carry[d]) begin
                if (({1'b0, r_coord[d]} + NW'(1)) < w_n[d]) begin
                    n_coord[d] = r_coord[d] + CW'(1);
                end else begin
                    n_coord[d]   = '0;
                    w_carry[d+1] = 1'b1;
                end
            end
        end
    end

    // accept-time decode
    logic w_load, w_coef, w_restart;
    assign w_load    = i_cmd.take && (i_action == swl1_pkg::ACT_LOAD);
    assign w_coef    = i_cmd.take && (i_action == swl1_pkg::ACT_COEF);
    assign w_restart = i_cmd.take && (i_action == swl1_pkg::ACT_RESTART);

    // weight table with per-entry valid bits
    logic [swl1_pkg::WGT_DEPTH-1:0] r_wval;
    logic [swl1_pkg::WGT_W-1:0]     w_rdata;
    logic [swl1_pkg::WIDX_W-1:0]    w_widx;
    assign w_widx = w_band;

    swl1_ram #(
        .WIDTH(swl1_pkg::WGT_W),
        .DEPTH(swl1_pkg::WGT_DEPTH)
    ) u_wtab (
        .i_clk  (i_clk),
        .i_we   (w_load),
        .i_waddr(i_weight_index),
        .i_wdata(i_weight_value),
        .i_re   (w_coef),
        .i_raddr(w_widx),
        .o_rdata(w_rdata)
    );

    // item payload
    logic [swl1_pkg::COEF_W-1:0] r_ar, r_ai;
    logic                        r_wv, r_zero_w, r_last;
    logic [swl1_pkg::SQ_W-1:0]   r_sq_re, r_sq_im, r_rad;
    logic [swl1_pkg::REM_W-1:0]  r_rem;
    logic [swl1_pkg::COEF_W-1:0] r_root;
    logic [swl1_pkg::STEP_W-1:0] r_step;
    logic [swl1_pkg::PROD_W-1:0] r_prod;

    // one root digit per cycle
    logic [swl1_pkg::REM_W+1:0]  w_rem_t, w_trial;
    assign w_rem_t = {r_rem, r_rad[swl1_pkg::SQ_W-1 -: 2]};
    assign w_trial = (swl1_pkg::REM_W+2)'({r_root, 2'b01});

    logic [swl1_pkg::COEF_W-1:0] w_mag;
    logic [swl1_pkg::WGT_W-1:0]  w_wgt;
    assign w_mag = i_cplx ? r_root : r_ar;
    assign w_wgt = (r_zero_w || !r_wv) ? '0 : w_rdata;

    always_ff @(posedge i_clk) begin
        if (w_coef) begin
            r_ar     <= i_coef_real[swl1_pkg::COEF_W-1] ?
                        swl1_pkg::COEF_W'(~i_coef_real + 1'b1) : i_coef_real;
            r_ai     <= i_coef_imag[swl1_pkg::COEF_W-1] ?
                        swl1_pkg::COEF_W'(~i_coef_imag + 1'b1) : i_coef_imag;
            r_wv     <= r_wval[w_widx];
            r_zero_w <= |w_lastel;
            r_last   <= w_carry[RD];
        end
        if (i_cmd.sq) begin
            r_sq_re <= r_ar * r_ar;
            r_sq_im <= r_ai * r_ai;
        end
        if (i_cmd.add) begin
            r_rad  <= r_sq_re + r_sq_im;
            r_rem  <= '0;
            r_root <= '0;
            r_step <= '0;
        end
        if (i_cmd.root) begin
            r_rad  <= {r_rad[swl1_pkg::SQ_W-3:0], 2'b00};
            r_step <= r_step + 1'b1;
            if (w_rem_t >= w_trial) begin
                r_rem  <= swl1_pkg::REM_W'(w_rem_t - w_trial);
                r_root <= {r_root[swl1_pkg::COEF_W-2:0], 1'b1};
            end else begin
                r_rem  <= swl1_pkg::REM_W'(w_rem_t);
                r_root <= {r_root[swl1_pkg::COEF_W-2:0], 1'b0};
            end
        end
        if (i_cmd.mul) begin
            r_prod <= w_wgt * w_mag;
        end
    end

    // saturating accumulator and result register
    logic [swl1_pkg::NORM_W-1:0] r_acc, n_acc;
    logic                        r_ovf, n_ovf;
    logic [swl1_pkg::NORM_W:0]   w_sum;
    logic                        r_out_valid;
    logic [swl1_pkg::NORM_W-1:0] r_norm;
    logic                        r_sat;

    assign w_sum = {1'b0, r_acc} + (swl1_pkg::NORM_W+1)'(r_prod);
    always_comb begin
        if (w_sum[swl1_pkg::NORM_W]) begin
            n_acc = '1;
            n_ovf = 1'b1;
        end else begin
            n_acc = w_sum[swl1_pkg::NORM_W-1:0];
            n_ovf = r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wval      <= '0;
            r_acc       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            for (int d = 0; d < RD; d++) begin
                r_coord[d] <= '0;
            end
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_load) begin
                r_wval[i_weight_index] <= 1'b1;
            end
            if (w_coef) begin
                r_coord <= n_coord;
            end
            if (w_restart) begin
                r_acc <= '0;
                r_ovf <= 1'b0;
                for (int d = 0; d < RD; d++) begin
                    r_coord[d] <= '0;
                end
            end
            if (i_cmd.acc) begin
                if (r_last) begin
                    r_out_valid <= 1'b1;
                    r_acc       <= '0;
                    r_ovf       <= 1'b0;
                end else begin
                    r_acc <= n_acc;
                    r_ovf <= n_ovf;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc && r_last) begin
            r_norm <= n_acc;
            r_sat  <= n_ovf;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_norm         = r_norm;
    assign o_sat          = r_sat;
    assign o_sts.coef      = (i_action == swl1_pkg::ACT_COEF);
    assign o_sts.cplx      = i_cplx;
    assign o_sts.root_done = (r_step == swl1_pkg::STEP_W'(swl1_pkg::ROOT_STEPS - 1));
    assign o_sts.out_block = r_last && r_out_valid && !i_out_ready;

`ifndef SYNTHESIS
    // a saturated pass reports the full-scale norm
    a_sat_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_sat) |-> (r_norm == '1))
        else $error("saturated result without full-scale norm");
    // restart leaves a clean pass
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_restart |=> (r_acc == '0 && !r_ovf))
        else $error("restart did not clear accumulator");
`endif

endmodule

[rtl/subband_weighted_l1_norm_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subband_weighted_l1_norm_core
// Weighted L1 norm of redundant Haar coefficients over up to six dimensions.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries items: weight loads, coefficients (column-major, dimension 0
//   fastest) and restarts. o_out carries one norm per pass, after the last
//   coefficient. Lengths and complex mode must be set over the APB port while
//   idle; the block does not enforce this. A weight load, restart or unused
//   action leaves the sequencer idle. A real coefficient passes accept, weight
//   multiply and accumulate; a complex one adds squaring, summing and the
//   square root unit, which resolves one result bit per cycle, after accept.
//   The result appears in the cycle after the accumulate of the last coefficient
//   and sits in an output register; input items keep being taken while it
//   waits. A later pass end stalls in accumulate until the result is taken.
//   Reset (synchronous, active low) sets lengths to 1, real mode, all weights
//   to zero and clears counters, accumulator and the output valid flag.
// ----------------------------------------------------------------------------
module subband_weighted_l1_norm_core #(
    parameter int NUM_DIMS    = 6,
    parameter int MAX_DIM_LEN = 2048
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    swl1_in_if.sink                        i_in,
    swl1_out_if.source                     o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [swl1_pkg::PADDR_W-1:0]   paddr,
    input  logic [swl1_pkg::PDATA_W-1:0]   pwdata,
    output logic [swl1_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);

    // configuration registers
    logic [swl1_pkg::LEN_W-1:0] r_len [swl1_pkg::REG_DIMS];
    logic                       r_cplx;
    logic [2:0]                 w_idx;
    logic                       w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cplx <= 1'b0;
            for (int d = 0; d < swl1_pkg::REG_DIMS; d++) begin
                r_len[d] <= swl1_pkg::LEN_W'(1);
            end
        end else if (w_wr) begin
            if (w_idx <= swl1_pkg::REG_LEN5) begin
                r_len[w_idx] <= pwdata[swl1_pkg::LEN_W-1:0];
            end else if (w_idx == swl1_pkg::REG_CPLX) begin
                r_cplx <= pwdata[0];
            end
        end
    end

    // register readback
    always_comb begin
        prdata = '0;
        if (w_idx <= swl1_pkg::REG_LEN5 && w_idx >= swl1_pkg::REG_LEN0) begin
            prdata = swl1_pkg::PDATA_W'(r_len[w_idx]);
        end else if (w_idx == swl1_pkg::REG_CPLX) begin
            prdata = swl1_pkg::PDATA_W'(r_cplx);
        end
    end

    swl1_pkg::t_cmd w_cmd;
    swl1_pkg::t_sts w_sts;

    swl1_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_in.valid),
        .o_ready(i_in.ready),
        .i_sts  (w_sts),
        .o_cmd  (w_cmd)
    );

    swl1_dp #(
        .NUM_DIMS   (NUM_DIMS),
        .MAX_DIM_LEN(MAX_DIM_LEN)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_action      (i_in.action),
        .i_weight_index(i_in.weight_index),
        .i_weight_value(i_in.weight_value),
        .i_coef_real   (i_in.coef_real),
        .i_coef_imag   (i_in.coef_imag),
        .i_len         (r_len),
        .i_cplx        (r_cplx),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_norm        (o_out.norm_value),
        .o_sat         (o_out.saturated)
    );

endmodule
